### design/grq_pkg.sv
// shared types and constants for the graph reachability query block
// no dependencies
`default_nettype none

package grq_pkg;

  localparam int unsigned NODES = 8;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned AdjW  = 64;
  localparam int unsigned InW   = 8;
  localparam int unsigned OutW  = 8;

  typedef struct packed {
    logic            valid;
    logic            kill;
    logic [IdxW-1:0] dst;
    logic [NODES-1:0] seen;
  } grq_stage_t;

endpackage

`default_nettype wire

### design/grq_adj_reg.sv
// adjacency matrix register, written through the configuration channel
// depends on grq_pkg
`default_nettype none

module grq_adj_reg
  import grq_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire logic [AdjW-1:0] wr_data_i,
  output      logic [AdjW-1:0] adj_o
);

  logic [AdjW-1:0] adj_q;
  logic [AdjW-1:0] adj_d;

  assign adj_d = wr_en_i ? wr_data_i : adj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q <= '0;
    end else begin
      adj_q <= adj_d;
    end
  end

  assign adj_o = adj_q;

endmodule

`default_nettype wire

### design/grq_expand_stage.sv
// one frontier expansion step with its pipeline register
// depends on grq_pkg
`default_nettype none

module grq_expand_stage
  import grq_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic [AdjW-1:0] adj_i,
  input  wire grq_stage_t      stage_i,
  output      grq_stage_t      stage_o
);

  grq_stage_t stage_q;
  grq_stage_t stage_d;
  logic [NODES-1:0] next_seen;

  // add successors of every node already reached
  always_comb begin
    next_seen = stage_i.seen;
    for (int unsigned n = 0; n < NODES; n++) begin
      if (stage_i.seen[n]) begin
        next_seen = next_seen | adj_i[n*NODES +: NODES];
      end
    end
    stage_d      = stage_i;
    stage_d.seen = next_seen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

### design/graph_reachability_query.sv
// top level of the graph reachability query: entry register, expansion pipeline, output
// depends on grq_pkg, grq_adj_reg, grq_expand_stage
//
//   channel   direction  handshake                       word
//   s_axis    in         s_axis_tvalid / s_axis_tready   [2:0] source, [5:3] dest
//   m_axis    out        m_axis_tvalid / m_axis_tready   [0] reachable
//   cfg       in         cfg_valid_i / cfg_ready_o       [63:0] adjacency bits
//
// one word in per cycle while the output word is not waiting; the result word passes the
// entry register, NODES expansion stages and the output register before it is valid
// the whole pipeline holds while the output word waits; nothing is lost or repeated
// reset clears the valid bits and the adjacency register; cfg is always ready
`default_nettype none

module graph_reachability_query
  import grq_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output      logic            s_axis_tready,
  input  wire logic [InW-1:0]  s_axis_tdata,   // [2:0] source_node, [5:3] dest_node
  output      logic            m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output      logic [OutW-1:0] m_axis_tdata,   // [0] reachable
  input  wire logic            cfg_valid_i,
  output      logic            cfg_ready_o,
  input  wire logic [AdjW-1:0] cfg_data_i
);

  logic            adv;
  logic [AdjW-1:0] adj;
  logic [IdxW-1:0] src;
  logic [IdxW-1:0] dst;
  grq_stage_t      entry_d;
  grq_stage_t      entry_q;
  grq_stage_t      pipe [NODES+1];
  logic            out_valid_q;
  logic            out_bit_q;
  logic            out_bit_d;

  assign cfg_ready_o = 1'b1;

  grq_adj_reg u_adj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cfg_valid_i),
    .wr_data_i(cfg_data_i),
    .adj_o    (adj)
  );

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  assign src = s_axis_tdata[IdxW-1:0];
  assign dst = s_axis_tdata[2*IdxW-1:IdxW];

  always_comb begin
    entry_d.valid = s_axis_tvalid;
    entry_d.kill  = (src == dst) || ({1'b0, src} >= (IdxW+1)'(NODES))
                    || ({1'b0, dst} >= (IdxW+1)'(NODES));
    entry_d.dst   = dst;
    entry_d.seen  = '0;
    if (!entry_d.kill) begin
      entry_d.seen[src] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q.valid <= 1'b0;
    end else if (adv) begin
      entry_q <= entry_d;
    end
  end

  assign pipe[0] = entry_q;

  for (genvar g = 0; g < NODES; g++) begin : g_step
    grq_expand_stage u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .adj_i  (adj),
      .stage_i(pipe[g]),
      .stage_o(pipe[g+1])
    );
  end

  assign out_bit_d = !pipe[NODES].kill && pipe[NODES].seen[pipe[NODES].dst];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pipe[NODES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_bit_q <= out_bit_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutW-1){1'b0}}, out_bit_q};

endmodule

`default_nettype wire

### design/grq_checker.sv
// port-level checks for graph_reachability_query, attached by bind
// depends on grq_pkg
`default_nettype none

module grq_checker
  import grq_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            s_axis_tready,
  input wire logic            m_axis_tvalid,
  input wire logic            m_axis_tready,
  input wire logic [OutW-1:0] m_axis_tdata,
  input wire logic            cfg_ready_o
);

  // waiting result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // a stalled output holds the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // padding bits of the result word stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutW-1:1] == '0)
    else $error("result padding not zero");

  // with the output word empty the input and the cfg channel are always ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready && cfg_ready_o)
    else $error("block not ready while output empty");

endmodule

bind graph_reachability_query grq_checker u_grq_checker (.*);

`default_nettype wire

### tb/sv/tb.sv
// testbench for graph_reachability_query: directed and random reachability queries
// against a frontier-expansion predictor, with bursty sender and stalling receiver
// depends on grq_pkg and graph_reachability_query
module tb;
  import grq_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned Latency   = NODES + 2;

  typedef struct {
    logic [IdxW-1:0] src;
    logic [IdxW-1:0] dst;
    bit              reach;
  } query_t;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata;   // [2:0] source_node, [5:3] dest_node
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;   // [0] reachable
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [AdjW-1:0] cfg_data_i;

  logic [AdjW-1:0] adjacency_model;
  query_t          pending_answers[$];
  int              error_count = 0;
  int              burst_left;
  int              idle_cycles = 0;
  logic [15:0]     ready_pattern = '1;
  int              ready_phase = 0;

  graph_reachability_query u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // grow the visited set from the source, one frontier step per node
  function automatic bit reachable_from(logic [AdjW-1:0] adj, logic [IdxW-1:0] src,
                                        logic [IdxW-1:0] dst);
    logic [NODES-1:0] seen;
    logic [NODES-1:0] grown;
    if (src == dst) return 1'b0;
    seen = '0;
    seen[src] = 1'b1;
    repeat (NODES) begin
      grown = seen;
      for (int n = 0; n < NODES; n++) begin
        if (seen[n]) grown = grown | adj[n*NODES +: NODES];
      end
      seen = grown;
    end
    return seen[dst];
  endfunction

  task automatic report_error(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_query(logic [IdxW-1:0] src, logic [IdxW-1:0] dst);
    int gap;
    query_t q;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(9, 1);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, dst, src};
    do @(posedge clk_i); while (!s_axis_tready);
    q.src   = src;
    q.dst   = dst;
    q.reach = reachable_from(adjacency_model, src, dst);
    pending_answers.push_back(q);
    burst_left--;
  endtask

  // drop valid and let every outstanding word drain
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_adjacency(logic [AdjW-1:0] value);
    wait_idle();
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    adjacency_model = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_empty_graph();
    write_adjacency('0);
    send_query(3'd0, 3'd7);
    send_query(3'd7, 3'd0);
    send_query(3'd3, 3'd3);
  endtask

  task automatic test_full_graph();
    write_adjacency('1);
    send_query(3'd0, 3'd7);
    send_query(3'd7, 3'd0);
    send_query(3'd5, 3'd5);
    send_query(3'd0, 3'd0);
    send_query(3'd7, 3'd7);
  endtask

  // the longest path, node 0 to node 7, needs every expansion step but one
  task automatic test_chain();
    logic [AdjW-1:0] adj;
    adj = '0;
    for (int n = 0; n < NODES - 1; n++) adj[n*NODES + n + 1] = 1'b1;
    write_adjacency(adj);
    send_query(3'd0, 3'd7);
    send_query(3'd7, 3'd0);
    send_query(3'd3, 3'd6);
    send_query(3'd6, 3'd3);
    send_query(3'd1, 3'd2);
  endtask

  // self loops and a ring still answer 0 for source equal to destination
  task automatic test_cycles();
    logic [AdjW-1:0] adj;
    adj = '0;
    for (int n = 0; n < NODES; n++) adj[n*NODES + n] = 1'b1;
    write_adjacency(adj);
    send_query(3'd2, 3'd2);
    send_query(3'd2, 3'd5);
    adj = '0;
    for (int n = 0; n < NODES; n++) adj[n*NODES + ((n + 1) % NODES)] = 1'b1;
    write_adjacency(adj);
    send_query(3'd4, 3'd4);
    send_query(3'd7, 3'd0);
    send_query(3'd6, 3'd5);
  endtask

  task automatic test_random_graphs();
    logic [AdjW-1:0] adj;
    logic [IdxW-1:0] src;
    logic [IdxW-1:0] dst;
    int percent;
    for (int phase = 0; phase < 14; phase++) begin
      case ($urandom_range(5))
        0: percent = 3;
        1: percent = 8;
        2: percent = 12;
        3: percent = 18;
        4: percent = 35;
        default: percent = 70;
      endcase
      for (int b = 0; b < AdjW; b++) adj[b] = ($urandom_range(99) < percent);
      write_adjacency(adj);
      repeat (118) begin
        src = IdxW'($urandom_range(NODES - 1));
        dst = ($urandom_range(7) == 0) ? src : IdxW'($urandom_range(NODES - 1));
        send_query(src, dst);
      end
    end
  endtask

  always @(posedge clk_i) begin
    query_t q;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        report_error($sformatf("unexpected word 0x%0h", m_axis_tdata));
      end else begin
        q = pending_answers.pop_front();
        if (m_axis_tdata[0] !== q.reach)
          report_error($sformatf("src %0d dst %0d reachable %b, want %b",
                                 q.src, q.dst, m_axis_tdata[0], q.reach));
      end
    end
  end

  // receiver stall pattern, a 16-bit mask re-drawn after it has been applied twice
  always @(negedge clk_i) begin
    if (ready_phase == 0)
      ready_pattern = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom());
    m_axis_tready = ready_pattern[ready_phase % 16];
    ready_phase   = (ready_phase + 1) % 32;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    adjacency_model = '0;
    burst_left      = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_graph();
    test_full_graph();
    test_chain();
    test_cycles();
    test_random_graphs();

    wait_idle();
    repeat (2 * Latency) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/grq_pkg.sv
design/grq_adj_reg.sv
design/grq_expand_stage.sv
design/graph_reachability_query.sv
design/grq_checker.sv
tb/sv/tb.sv
